[sv/mwd_pkg.sv]
// mwd_pkg: shared types and constants of the moving window deconvolution filter
// no dependencies

package mwd_pkg;

  localparam int CFG_DATA_BITS  = 25;
  localparam int CFG_INDEX_BITS = 2;
  localparam int DIFF_LEN_BITS  = 14;
  localparam int AVG_LEN_BITS   = 11;
  localparam int ACC_BITS       = 64;
  localparam int OUT_BITS       = 40;
  localparam int SUM_BITS       = 52;
  localparam int WIDE_BITS      = 54;

  localparam logic [CFG_DATA_BITS-1:0] ONE_Q24      = 25'h100_0000;
  localparam logic [CFG_DATA_BITS-1:0] DECAY_RESET  = 25'd16776525;
  localparam logic [CFG_DATA_BITS-1:0] RECIP_RESET  = 25'd16777;
  localparam int                       DIFF_LEN_RESET = 8000;
  localparam int                       AVG_LEN_RESET  = 1000;

  localparam logic signed [WIDE_BITS-1:0] OUT_MAX = 54'sh7F_FFFF_FFFF;
  localparam logic signed [WIDE_BITS-1:0] OUT_MIN = -OUT_MAX - 54'sd1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DECAY_FACTOR   = 2'd0,
    REG_DIFF_LENGTH    = 2'd1,
    REG_AVG_LENGTH     = 2'd2,
    REG_AVG_RECIPROCAL = 2'd3
  } cfg_reg_t;

  function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [WIDE_BITS-1:0] v);
    logic signed [OUT_BITS-1:0] r;
    if (v > OUT_MAX) begin
      r = OUT_MAX[OUT_BITS-1:0];
    end else if (v < OUT_MIN) begin
      r = OUT_MIN[OUT_BITS-1:0];
    end else begin
      r = v[OUT_BITS-1:0];
    end
    return r;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] clamp_q24(input logic [CFG_DATA_BITS-1:0] v);
    return (v > ONE_Q24) ? ONE_Q24 : v;
  endfunction

endpackage

[sv/mwd_if.sv]
// mwd_in_if, mwd_out_if: valid/ready channels for samples and filter results
// depends on mwd_pkg

interface mwd_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface mwd_out_if;
  import mwd_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] diff_value;
  logic signed [OUT_BITS-1:0] avg_value;

  modport source (output valid, output diff_value, output avg_value, input ready);
  modport sink (input valid, input diff_value, input avg_value, output ready);
endinterface

[sv/mwd_ram.sv]
// mwd_ram: single port write, single port read memory with registered read data
// no dependencies

module mwd_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/moving_window_deconvolution.sv]
// Moving window deconvolution filter. Each accepted sample word yields one result word holding
// the M-step difference of the decay-corrected signal and its L-sample moving average, both Q8
// and saturated to 40 bits; the average repeats the difference for the first L-1 samples.
// A sample passes states ACC, DELTA, DIFF, SUM, MLO, MHI and AVG to the result register, AVG
// waiting while that holds an untaken result; one shared 27x26 multiplier forms the decay and
// both average products, and both delay line memories are read and written. A new sample is
// taken once the previous one reaches the output register, which holds it until taken. Delay
// lines start as zero through fill counts, so there is no clearing pass after reset. The user
// must have configuration written through cfg_we/cfg_index/cfg_wdata while idle; unenforced.
// depends on mwd_pkg, mwd_if, mwd_ram

module moving_window_deconvolution #(
  parameter int MAX_DIFF_LENGTH = 8192,
  parameter int MAX_AVG_LENGTH  = 1024,
  parameter int SAMPLE_BITS     = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mwd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mwd_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  mwd_in_if.sink                              din,
  mwd_out_if.source                           dout
);
  import mwd_pkg::*;

  localparam int AW = $clog2(MAX_DIFF_LENGTH);
  localparam int MW = $clog2(MAX_DIFF_LENGTH + 1);
  localparam int BW = $clog2(MAX_AVG_LENGTH);
  localparam int LW = $clog2(MAX_AVG_LENGTH + 1);
  localparam int KW = SAMPLE_BITS + CFG_DATA_BITS;
  localparam int MUL_A_BITS = 27;
  localparam int MUL_B_BITS = CFG_DATA_BITS + 1;
  localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;
  localparam int LO_BITS = 26;
  localparam int PL_BITS = LO_BITS + CFG_DATA_BITS;
  localparam int M_RESET = (DIFF_LEN_RESET > MAX_DIFF_LENGTH) ? MAX_DIFF_LENGTH : DIFF_LEN_RESET;
  localparam int L_RESET = (AVG_LEN_RESET > MAX_AVG_LENGTH) ? MAX_AVG_LENGTH : AVG_LEN_RESET;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ACC   = 8'b0000_0010,
    S_DELTA = 8'b0000_0100,
    S_DIFF  = 8'b0000_1000,
    S_SUM   = 8'b0001_0000,
    S_MLO   = 8'b0010_0000,
    S_MHI   = 8'b0100_0000,
    S_AVG   = 8'b1000_0000
  } state_t;

  state_t state;

  logic [CFG_DATA_BITS-1:0] k;
  logic [CFG_DATA_BITS-1:0] r;
  logic [MW-1:0]            m;
  logic [LW-1:0]            l;

  logic signed [SAMPLE_BITS-1:0] prev;
  logic signed [SAMPLE_BITS-1:0] x;
  logic [ACC_BITS-1:0]           acc;
  logic signed [KW-1:0]          prod_k;
  logic [ACC_BITS-1:0]           delayed;
  logic [ACC_BITS-1:0]           delta;
  logic signed [OUT_BITS-1:0]    diff;
  logic signed [OUT_BITS-1:0]    old_diff;
  logic signed [SUM_BITS-1:0]    sum;
  logic [PL_BITS-1:0]            plo;
  logic signed [PL_BITS-1:0]     phi;
  logic [LW-1:0]                 warmup;

  logic [AW-1:0] pos_d;
  logic [MW-1:0] fill_d;
  logic [BW-1:0] pos_a;
  logic [LW-1:0] fill_a;

  logic                       out_valid;
  logic signed [OUT_BITS-1:0] out_diff;
  logic signed [OUT_BITS-1:0] out_avg;

  logic [MW:0]            rd_d_full;
  logic [AW-1:0]          rd_d;
  logic [LW:0]            rd_a_full;
  logic [BW-1:0]          rd_a;
  logic [ACC_BITS-1:0]    dl_rdata;
  logic [OUT_BITS-1:0]    al_rdata;

  logic signed [MUL_A_BITS-1:0] mul_a;
  logic signed [MUL_B_BITS-1:0] mul_b;
  logic signed [MUL_P_BITS-1:0] mul_p;

  logic [ACC_BITS-1:0]         acc_next;
  logic signed [WIDE_BITS-1:0] diff_wide;
  logic signed [WIDE_BITS-1:0] avg_wide;
  logic signed [OUT_BITS-1:0]  avg_sel;
  logic                        in_warmup;
  logic                        out_free;
  logic [31:0]                 cfg_len;

  assign din.ready       = (state == S_IDLE);
  assign dout.valid      = out_valid;
  assign dout.diff_value = out_diff;
  assign dout.avg_value  = out_avg;
  assign out_free        = !out_valid || dout.ready;

  // delay line read addresses
  always_comb begin
    if ((MW + 1)'(pos_d) >= (MW + 1)'(m)) begin
      rd_d_full = (MW + 1)'(pos_d) - (MW + 1)'(m);
    end else begin
      rd_d_full = (MW + 1)'(pos_d) + (MW + 1)'(MAX_DIFF_LENGTH) - (MW + 1)'(m);
    end
    if ((LW + 1)'(pos_a) >= (LW + 1)'(l)) begin
      rd_a_full = (LW + 1)'(pos_a) - (LW + 1)'(l);
    end else begin
      rd_a_full = (LW + 1)'(pos_a) + (LW + 1)'(MAX_AVG_LENGTH) - (LW + 1)'(l);
    end
  end

  assign rd_d = rd_d_full[AW-1:0];
  assign rd_a = rd_a_full[BW-1:0];

  mwd_ram #(
    .WIDTH (ACC_BITS),
    .DEPTH (MAX_DIFF_LENGTH)
  ) u_deconv_line (
    .clk   (clk),
    .we    (state == S_DELTA),
    .waddr (pos_d),
    .wdata (acc),
    .raddr (rd_d),
    .rdata (dl_rdata)
  );

  mwd_ram #(
    .WIDTH (OUT_BITS),
    .DEPTH (MAX_AVG_LENGTH)
  ) u_diff_line (
    .clk   (clk),
    .we    (state == S_SUM),
    .waddr (pos_a),
    .wdata (diff),
    .raddr (rd_a),
    .rdata (al_rdata)
  );

  // shared multiplier
  always_comb begin
    mul_b = $signed({1'b0, r});
    case (state)
      S_MLO: begin
        mul_a = $signed({1'b0, sum[LO_BITS-1:0]});
      end
      S_MHI: begin
        mul_a = MUL_A_BITS'($signed(sum[SUM_BITS-1:LO_BITS]));
      end
      default: begin
        mul_a = MUL_A_BITS'(prev);
        mul_b = $signed({1'b0, k});
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign acc_next  = acc + (ACC_BITS'(x) <<< 24) - ACC_BITS'(prod_k);
  assign diff_wide = WIDE_BITS'($signed(delta[ACC_BITS-1:16])) + WIDE_BITS'(delta[15]);
  assign avg_wide  = (WIDE_BITS'(phi) <<< 2) + WIDE_BITS'(plo[PL_BITS-1:24])
                     + WIDE_BITS'(plo[23]);
  assign in_warmup = ((LW + 1)'(warmup) + (LW + 1)'(1)) < (LW + 1)'(l);
  assign avg_sel   = in_warmup ? diff : sat_out(avg_wide);
  assign cfg_len   = (cfg_index == REG_DIFF_LENGTH) ? 32'(cfg_wdata[DIFF_LEN_BITS-1:0])
                                                     : 32'(cfg_wdata[AVG_LEN_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      k         <= DECAY_RESET;
      r         <= RECIP_RESET;
      m         <= MW'(M_RESET);
      l         <= LW'(L_RESET);
      prev      <= '0;
      acc       <= '0;
      sum       <= '0;
      warmup    <= '0;
      pos_d     <= '0;
      fill_d    <= '0;
      pos_a     <= '0;
      fill_a    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DECAY_FACTOR: begin
            k <= clamp_q24(cfg_wdata);
          end
          REG_DIFF_LENGTH: begin
            if (cfg_len == 32'd0) begin
              m <= MW'(1);
            end else if (cfg_len > 32'(MAX_DIFF_LENGTH)) begin
              m <= MW'(MAX_DIFF_LENGTH);
            end else begin
              m <= MW'(cfg_len);
            end
          end
          REG_AVG_LENGTH: begin
            if (cfg_len == 32'd0) begin
              l <= LW'(1);
            end else if (cfg_len > 32'(MAX_AVG_LENGTH)) begin
              l <= LW'(MAX_AVG_LENGTH);
            end else begin
              l <= LW'(cfg_len);
            end
          end
          REG_AVG_RECIPROCAL: begin
            r <= clamp_q24(cfg_wdata);
          end
          default: begin
          end
        endcase
      end

      if (out_valid && dout.ready && state != S_AVG) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (din.valid) begin
            x      <= SAMPLE_BITS'(din.sample);
            prod_k <= KW'(mul_p);
            state  <= S_ACC;
          end
        end
        S_ACC: begin
          acc      <= acc_next;
          prev     <= x;
          delayed  <= (MW'(rd_d) < fill_d) ? dl_rdata : '0;
          old_diff <= (LW'(rd_a) < fill_a) ? $signed(al_rdata) : '0;
          state    <= S_DELTA;
        end
        S_DELTA: begin
          delta <= acc - delayed;
          pos_d <= ((MW'(pos_d) + MW'(1)) == MW'(MAX_DIFF_LENGTH)) ? '0 : pos_d + AW'(1);
          if (fill_d != MW'(MAX_DIFF_LENGTH)) begin
            fill_d <= fill_d + MW'(1);
          end
          state <= S_DIFF;
        end
        S_DIFF: begin
          diff  <= sat_out(diff_wide);
          state <= S_SUM;
        end
        S_SUM: begin
          sum   <= sum + SUM_BITS'(diff) - SUM_BITS'(old_diff);
          pos_a <= ((LW'(pos_a) + LW'(1)) == LW'(MAX_AVG_LENGTH)) ? '0 : pos_a + BW'(1);
          if (fill_a != LW'(MAX_AVG_LENGTH)) begin
            fill_a <= fill_a + LW'(1);
          end
          state <= S_MLO;
        end
        S_MLO: begin
          plo   <= PL_BITS'(mul_p);
          state <= S_MHI;
        end
        S_MHI: begin
          phi   <= PL_BITS'(mul_p);
          state <= S_AVG;
        end
        S_AVG: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_diff  <= diff;
            out_avg   <= avg_sel;
            if (in_warmup) begin
              warmup <= warmup + LW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_starts_item: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> state == S_ACC)
    else $error("accepted sample did not start processing");

  a_result_from_avg: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_AVG))
    else $error("result word loaded outside the final step");

  a_fill_advances: assert property (@(posedge clk) disable iff (rst)
    state == S_DELTA |=> fill_d != $past(fill_d) || fill_d == MW'(MAX_DIFF_LENGTH))
    else $error("deconvolution fill count stalled before full");

  a_warmup_bound: assert property (@(posedge clk) disable iff (rst)
    (LW + 1)'(warmup) < (LW + 1)'(MAX_AVG_LENGTH))
    else $error("warm-up count out of range");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking testbench for the moving window deconvolution filter; predicts every result
// word from its own bit-exact copy of the filter state, most tests idling both sides at random
// depends on mwd_pkg, mwd_if and moving_window_deconvolution

module tb;
  import mwd_pkg::*;

  localparam int     DIFF_DEPTH      = 8192;
  localparam int     AVG_DEPTH       = 1024;
  localparam int     HOLD_OFF_CYCLES = 300;
  localparam int     SETTLE_CYCLES   = 12;
  localparam int     WATCHDOG_LIMIT  = 4000;
  localparam longint UNITY_Q24       = 64'sd16777216;
  localparam longint OUT_HI          = (64'sd1 <<< (OUT_BITS - 1)) - 64'sd1;
  localparam longint OUT_LO          = -OUT_HI - 64'sd1;

  typedef struct {
    logic signed [OUT_BITS-1:0] diff;
    logic signed [OUT_BITS-1:0] avg;
  } mwd_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

  mwd_in_if #(.SAMPLE_BITS(16)) din ();
  mwd_out_if dout ();

  moving_window_deconvolution dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .din       (din),
    .dout      (dout)
  );

  always #1 clk = ~clk;

  // filter registers as seen by the predictor
  logic [CFG_DATA_BITS-1:0] decay_q24 = DECAY_RESET;
  logic [DIFF_LEN_BITS-1:0] diff_len  = DIFF_LEN_BITS'(DIFF_LEN_RESET);
  logic [AVG_LEN_BITS-1:0]  avg_len   = AVG_LEN_BITS'(AVG_LEN_RESET);
  logic [CFG_DATA_BITS-1:0] avg_recip = RECIP_RESET;

  // filter state as seen by the predictor
  longint      last_sample = 0;
  logic [63:0] integ_q24 = '0;
  logic [63:0] integ_history [DIFF_DEPTH];
  longint      diff_history [AVG_DEPTH];
  longint      window_total = 0;
  int          warm_samples = 0;
  int          integ_wr = 0;
  int          diff_wr = 0;

  mwd_result_t pending[$];
  int          errors = 0;
  int          quiet_cycles = 0;
  int          n_samples = 0;
  int          n_settings = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  function automatic mwd_result_t deconvolve_sample(input logic signed [15:0] value);
    longint      x, k, r, term, d24, diff, old, avg, lo, hi, part, total;
    int          m, l, rd;
    logic [63:0] delayed;
    logic signed [SUM_BITS-1:0] total52;
    mwd_result_t res;
    x = value;
    k = decay_q24;
    if (k > UNITY_Q24) k = UNITY_Q24;
    r = avg_recip;
    if (r > UNITY_Q24) r = UNITY_Q24;
    m = int'(diff_len);
    if (m < 1) m = 1;
    if (m > DIFF_DEPTH) m = DIFF_DEPTH;
    l = int'(avg_len);
    if (l < 1) l = 1;
    if (l > AVG_DEPTH) l = AVG_DEPTH;

    // decay removal, wrapping at 64 bits
    term = x * UNITY_Q24 - k * last_sample;
    integ_q24 = integ_q24 + term;
    last_sample = x;

    // m-step difference, q24 down to q8
    rd = (integ_wr >= m) ? integ_wr - m : integ_wr + DIFF_DEPTH - m;
    delayed = integ_history[rd];
    integ_history[integ_wr] = integ_q24;
    integ_wr = (integ_wr + 1 >= DIFF_DEPTH) ? 0 : integ_wr + 1;
    d24 = integ_q24 - delayed;
    diff = d24 >>> 16;
    if (d24[15]) diff = diff + 1;
    if (diff > OUT_HI) diff = OUT_HI;
    else if (diff < OUT_LO) diff = OUT_LO;

    // running sum over the last l differences
    rd = (diff_wr >= l) ? diff_wr - l : diff_wr + AVG_DEPTH - l;
    old = diff_history[rd];
    diff_history[diff_wr] = diff;
    diff_wr = (diff_wr + 1 >= AVG_DEPTH) ? 0 : diff_wr + 1;
    total = window_total + diff - old;
    total52 = total[SUM_BITS-1:0];
    window_total = total52;

    lo = window_total & 64'sh3FF_FFFF;
    hi = window_total >>> 26;
    part = lo * r;
    avg = hi * r * 4 + (part >>> 24);
    if (part[23]) avg = avg + 1;
    if (avg > OUT_HI) avg = OUT_HI;
    else if (avg < OUT_LO) avg = OUT_LO;

    if (warm_samples + 1 < l) begin
      avg = diff;
      if (warm_samples < AVG_DEPTH) warm_samples++;
    end
    res.diff = diff[OUT_BITS-1:0];
    res.avg = avg[OUT_BITS-1:0];
    return res;
  endfunction

  task automatic send_sample(input logic signed [15:0] value);
    int gap;
    mwd_result_t expect_word;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      din.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din.valid <= 1'b1;
    din.sample <= value;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    expect_word = deconvolve_sample(value);
    pending.insert(pending.size(), expect_word);
    n_samples++;
  endtask

  task automatic drain_results();
    din.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_DECAY_FACTOR:   decay_q24 = data;
      REG_DIFF_LENGTH:    diff_len = data[DIFF_LEN_BITS-1:0];
      REG_AVG_LENGTH:     avg_len = data[AVG_LEN_BITS-1:0];
      REG_AVG_RECIPROCAL: avg_recip = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_DATA_BITS-1:0] decay, input logic [CFG_DATA_BITS-1:0] m,
                           input logic [CFG_DATA_BITS-1:0] l, input logic [CFG_DATA_BITS-1:0] recip);
    write_reg(REG_DECAY_FACTOR, decay);
    write_reg(REG_DIFF_LENGTH, m);
    write_reg(REG_AVG_LENGTH, l);
    write_reg(REG_AVG_RECIPROCAL, recip);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  // first samples after reset: zero history, early differences and warm-up
  task automatic test_warmup_extremes();
    logic signed [15:0] pattern [20];
    pattern = '{16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, 16'sh0000, 16'sh0000,
                16'sh0001, -16'sh0001, 16'sh5555, 16'shAAAA, 16'sh7FFF, -16'sh8000,
                16'sh7FFF, -16'sh8000, 16'sh0000, 16'sh3039, -16'sh3039, 16'sh7FFE,
                16'sh8001, 16'sh0000};
    foreach (pattern[i]) send_sample(pattern[i]);
    drain_results();
  endtask

  // clamped and boundary register values, including bits above each register width
  task automatic test_register_extremes();
    logic [CFG_DATA_BITS-1:0] settings [6][4];
    settings = '{
      '{25'd0,          25'd0,          25'd0,          25'd0},
      '{25'h1FF_FFFF,   25'd16383,      25'd2047,       25'h1FF_FFFF},
      '{ONE_Q24,        25'd8192,       25'd1024,       ONE_Q24},
      '{25'd1,          25'd1,          25'd1,          25'd1},
      '{25'h0AB_CDEF,   25'h1FF_C005,   25'h1FF_F803,   25'd5592405},
      '{DECAY_RESET,    25'd2,          25'd2,          25'h080_0000}
    };
    foreach (settings[i]) begin
      configure(settings[i][0], settings[i][1], settings[i][2], settings[i][3]);
      repeat (20) send_sample(16'($urandom()));
      drain_results();
    end
  endtask

  // random windows with pulse-like, noisy and extreme content
  task automatic test_random_windows();
    logic [CFG_DATA_BITS-1:0] decay, m, l, recip;
    int lc, level;
    logic signed [15:0] value;
    level = 0;
    repeat (10) begin
      case ($urandom_range(0, 3))
        0:       decay = 25'($urandom());
        1:       decay = ONE_Q24;
        default: decay = ONE_Q24 - 25'($urandom_range(0, 4096));
      endcase
      m = ($urandom_range(0, 7) == 0) ? 25'($urandom_range(0, 16383)) : 25'($urandom_range(1, 48));
      l = ($urandom_range(0, 7) == 0) ? 25'($urandom_range(0, 2047)) : 25'($urandom_range(1, 40));
      lc = int'(l[AVG_LEN_BITS-1:0]);
      if (lc < 1) lc = 1;
      if (lc > AVG_DEPTH) lc = AVG_DEPTH;
      if ($urandom_range(0, 3) == 0) recip = 25'($urandom());
      else recip = 25'((int'(ONE_Q24) + lc / 2) / lc);
      configure(decay, m, l, recip);
      repeat (20) begin
        if ($urandom_range(0, 40) == 0) level = int'(16'sh7FFF) - int'($urandom_range(0, 65535));
        level = level - (level >>> 5);
        case ($urandom_range(0, 3))
          0:       value = 16'($urandom());
          1:       value = ($urandom_range(0, 1) == 0) ? 16'sh7FFF : -16'sh8000;
          default: value = 16'(level + int'($urandom_range(0, 6)) - 3);
        endcase
        send_sample(value);
      end
      drain_results();
    end
  endtask

  // results held off long enough for the filter to stall its input
  task automatic test_input_stall();
    configure(DECAY_RESET, 25'd20, 25'd16, 25'd1048576);
    hold_req = 1'b1;
    repeat (40) send_sample(16'($urandom()));
    wait (hold_done);
    drain_results();
  endtask

  // long ramps of one sign drive the window average into both saturation limits
  task automatic test_average_saturation();
    configure(25'd0, 25'd256, 25'd512, ONE_Q24);
    repeat (550) send_sample(16'($urandom_range(32000, 32767)));
    repeat (650) send_sample(16'h8000 + 16'($urandom_range(0, 768)));
    drain_results();
  endtask

  task automatic test_back_to_back();
    configure(DECAY_RESET, 25'd100, 25'd32, 25'd524288);
    idle_on = 1'b0;
    repeat (100) send_sample(16'($urandom()));
    drain_results();
  endtask

  initial begin : result_sink
    int gap;
    dout.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        dout.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        dout.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 4);
        dout.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        dout.ready <= 1'b1;
      end else begin
        dout.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    mwd_result_t want;
    if (!rst && dout.valid && dout.ready) begin
      if (pending.size() == 0) begin
        $error("result word with no sample outstanding: diff_value %0d avg_value %0d",
               dout.diff_value, dout.avg_value);
        errors++;
      end else begin
        want = pending.pop_front();
        if (dout.diff_value !== want.diff) begin
          $error("diff_value: expected %0d, got %0d", want.diff, dout.diff_value);
          errors++;
        end
        if (dout.avg_value !== want.avg) begin
          $error("avg_value: expected %0d, got %0d", want.avg, dout.avg_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((din.valid && din.ready) || (dout.valid && dout.ready)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    din.valid <= 1'b0;
    din.sample <= '0;
    for (int i = 0; i < DIFF_DEPTH; i++) integ_history[i] = '0;
    for (int i = 0; i < AVG_DEPTH; i++) diff_history[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_warmup_extremes();
    test_register_extremes();
    test_random_windows();
    test_input_stall();
    test_average_saturation();
    test_back_to_back();

    if (pending.size() != 0) $error("%0d result words never arrived", pending.size());
    $display("run covered %0d samples under %0d register settings plus reset values,",
             n_samples, n_settings);
    $display("with clamped windows, a stalled output and both average saturation limits");
    if (errors == 0 && pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
